// ----- rtl/qsu_pkg.sv -----
// Shared types, codes and helper functions for the quoted string unescaper.
package qsu_pkg;

    // Input mode codes
    localparam logic [1:0] MODE_OPEN    = 2'd0;
    localparam logic [1:0] MODE_CONTENT = 2'd1;
    localparam logic [1:0] MODE_END     = 2'd2;

    // Escape characters and the control codes they stand for
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CC_BS     = 8'h08;
    localparam logic [7:0] CC_FF     = 8'h0C;
    localparam logic [7:0] CC_LF     = 8'h0A;
    localparam logic [7:0] CC_CR     = 8'h0D;
    localparam logic [7:0] CC_TAB    = 8'h09;

    // Octal escapes end after this many digits
    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    // One result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_beat;

    // Results of one decoded item: zero, one or two beats
    typedef struct packed {
        logic [1:0] num;
        t_beat      beat0;
        t_beat      beat1;
    } t_step_res;

    // Hex digit test and value: {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // Octal digit test: '0' through '7'
    function automatic logic is_oct(input logic [7:0] c);
        return (c[7:3] == 5'b00110);
    endfunction

endpackage

// ----- rtl/quoted_string_unescaper_top.sv -----
// Top level of the quoted string unescaper: input register, decoder, result queue.
//
// Decodes a quoted string one byte per beat. An opening beat (mode 0) sets the
// terminator; content beats (mode 1) produce decoded bytes, with C-style escapes
// (\b \f \n \r \t, \x hex, up to three octal digits) resolved; an end beat (mode 2)
// flushes a pending value and closes the string. Each beat gives zero, one or two
// result beats; last marks the close. Input beats are taken one per cycle while
// the result queue has room: a beat is held in the input register, decoded from
// there, and its results land in a four-entry queue. Input stalls only while that
// queue holds more than two beats, so a sustained rate of one beat per cycle holds
// as long as the sink takes results as fast as they come. The first result of a
// beat passes the input register and the queue before it is valid at the output.
module quoted_string_unescaper_top
    import qsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_byte,
    output logic       o_has_byte,
    output logic       o_last
);

    logic       r_in_valid;
    logic [1:0] r_in_mode;
    logic [7:0] r_in_char;
    logic       space;
    logic       step;
    t_step_res  res;
    t_beat      beat;

    assign step       = r_in_valid && space;
    assign o_in_ready = !r_in_valid || space;

    // Hold the accepted beat until the decoder takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_in_ready) begin
            r_in_mode <= i_mode;
            r_in_char <= i_char_in;
        end
    end

    qsu_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_mode    (r_in_mode),
        .i_char_in (r_in_char),
        .o_res     (res)
    );

    qsu_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_space (space),
        .o_beat  (beat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready)
    );

    assign o_data_byte = beat.data_byte;
    assign o_has_byte  = beat.has_byte;
    assign o_last      = beat.last;

    // A held beat that is not decoded stays held
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_mode) && $stable(r_in_char)))
        else $error("input beat dropped before decode");

    // Decoder results only come from a held beat
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.num != 2'd0) |-> step)
        else $error("result without a decoded beat");

    // A beat without a byte carries zero data and marks the close
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> (o_data_byte == 8'd0 && o_last))
        else $error("empty result beat is malformed");

endmodule

// ----- rtl/qsu_decode.sv -----
// Escape decoder: parse state and the result beats of one registered byte.
module qsu_decode
    import qsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_in,
    output t_step_res  o_res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_quote, n_quote;
    logic [7:0] r_esc_val, n_esc_val;
    logic [1:0] r_oct_cnt, n_oct_cnt;

    t_step_res  res;
    t_beat      body_beat;
    logic       body_emit;
    logic [2:0] body_phase;
    t_beat      val_beat;
    logic [4:0] hd;
    logic [1:0] oct_inc;

    // Handle a byte as ordinary string body
    always_comb begin
        body_beat = '{data_byte: 8'd0, has_byte: 1'b0, last: 1'b0};
        body_emit = 1'b0;
        if (i_char_in == r_quote) begin
            body_beat.last = 1'b1;
            body_emit      = 1'b1;
            body_phase     = PH_IDLE;
        end else if (i_char_in == CH_BSLASH) begin
            body_phase     = PH_ESC;
        end else begin
            body_beat = '{data_byte: i_char_in, has_byte: 1'b1, last: 1'b0};
            body_emit      = 1'b1;
            body_phase     = PH_BODY;
        end
    end

    assign val_beat = '{data_byte: r_esc_val, has_byte: 1'b1, last: 1'b0};
    assign hd       = hex_digit(i_char_in);
    assign oct_inc  = r_oct_cnt + 2'd1;

    // Next state and result beats for the current byte
    always_comb begin
        res       = '0;
        n_phase   = r_phase;
        n_quote   = r_quote;
        n_esc_val = r_esc_val;
        n_oct_cnt = r_oct_cnt;
        if (i_step) begin
            if (i_mode == MODE_OPEN) begin
                n_quote   = i_char_in;
                n_esc_val = 8'd0;
                n_oct_cnt = 2'd0;
                n_phase   = PH_BODY;
            end else if (i_mode == MODE_END) begin
                if (r_phase == PH_HEX || r_phase == PH_OCT) begin
                    res.num   = 2'd2;
                    res.beat0 = val_beat;
                    res.beat1 = '{data_byte: 8'd0, has_byte: 1'b0, last: 1'b1};
                end else if (r_phase == PH_BODY || r_phase == PH_ESC) begin
                    res.num   = 2'd1;
                    res.beat0 = '{data_byte: 8'd0, has_byte: 1'b0, last: 1'b1};
                end
                if (r_phase != PH_IDLE && r_phase <= PH_OCT) begin
                    n_phase   = PH_IDLE;
                    n_esc_val = 8'd0;
                    n_oct_cnt = 2'd0;
                end
            end else if (i_mode == MODE_CONTENT) begin
                unique case (r_phase)
                    PH_BODY: begin
                        res.num   = {1'b0, body_emit};
                        res.beat0 = body_beat;
                        n_phase   = body_phase;
                    end
                    PH_ESC: begin
                        n_esc_val = 8'd0;
                        n_oct_cnt = 2'd0;
                        n_phase   = PH_BODY;
                        res.num   = 2'd1;
                        res.beat0 = '{data_byte: i_char_in, has_byte: 1'b1, last: 1'b0};
                        case (i_char_in)
                            CH_LC_B: res.beat0.data_byte = CC_BS;
                            CH_LC_F: res.beat0.data_byte = CC_FF;
                            CH_LC_N: res.beat0.data_byte = CC_LF;
                            CH_LC_R: res.beat0.data_byte = CC_CR;
                            CH_LC_T: res.beat0.data_byte = CC_TAB;
                            CH_LC_X, CH_UC_X: begin
                                res.num = 2'd0;
                                n_phase = PH_HEX;
                            end
                            default: begin
                                if (is_oct(i_char_in)) begin
                                    res.num   = 2'd0;
                                    n_esc_val = {5'd0, i_char_in[2:0]};
                                    n_oct_cnt = 2'd1;
                                    n_phase   = PH_OCT;
                                end
                            end
                        endcase
                    end
                    PH_HEX: begin
                        if (hd[4]) begin
                            n_esc_val = {r_esc_val[3:0], hd[3:0]};
                        end else begin
                            res.num   = {body_emit, ~body_emit};
                            res.beat0 = val_beat;
                            res.beat1 = body_beat;
                            n_esc_val = 8'd0;
                            n_phase   = body_phase;
                        end
                    end
                    PH_OCT: begin
                        if (is_oct(i_char_in)) begin
                            n_esc_val = {r_esc_val[4:0], i_char_in[2:0]};
                            n_oct_cnt = oct_inc;
                            if (oct_inc == OCT_MAX_DIGITS) begin
                                res.num   = 2'd1;
                                res.beat0 = '{data_byte: n_esc_val, has_byte: 1'b1,
                                              last: 1'b0};
                                n_esc_val = 8'd0;
                                n_oct_cnt = 2'd0;
                                n_phase   = PH_BODY;
                            end
                        end else begin
                            res.num   = {body_emit, ~body_emit};
                            res.beat0 = val_beat;
                            res.beat1 = body_beat;
                            n_esc_val = 8'd0;
                            n_oct_cnt = 2'd0;
                            n_phase   = body_phase;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Advance parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_quote   <= 8'd0;
            r_esc_val <= 8'd0;
            r_oct_cnt <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_quote   <= n_quote;
            r_esc_val <= n_esc_val;
            r_oct_cnt <= n_oct_cnt;
        end
    end

    assign o_res = res;

    // Gathered value is clear whenever no escape is open
    a_val_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_BODY) |-> (r_esc_val == 8'd0 && r_oct_cnt == 2'd0))
        else $error("escape value left over outside an escape");

    // An open octal escape holds one or two digits
    a_oct_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OCT) |-> (r_oct_cnt == 2'd1 || r_oct_cnt == 2'd2))
        else $error("octal digit count out of range");

    // With two beats the first is a plain data byte
    a_two_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.num == 2'd2) |-> (o_res.beat0.has_byte && !o_res.beat0.last))
        else $error("first of two beats is not a data byte");

    // Beats taken while idle give nothing, opening beats included
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (o_res.num == 2'd0))
        else $error("result while idle");

endmodule

// ----- rtl/qsu_outq.sv -----
// Four-entry result queue: takes up to two beats a cycle, hands out one.
module qsu_outq
    import qsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_res i_res,
    output logic      o_space,
    output t_beat     o_beat,
    output logic      o_valid,
    input  logic      i_ready
);

    t_beat      r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       rd;

    assign rd      = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_beat  = r_mem[r_rp];
    assign o_space = (r_cnt <= 3'd2);

    // Advance pointers and fill level
    always_comb begin
        n_wp  = r_wp + i_res.num;
        n_rp  = r_rp + {1'b0, rd};
        n_cnt = r_cnt + {1'b0, i_res.num} - {2'b00, rd};
    end

    // Store incoming beats
    always_ff @(posedge i_clk) begin
        if (i_res.num != 2'd0) begin
            r_mem[r_wp] <= i_res.beat0;
        end
        if (i_res.num == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res.beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Never overfill
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    // Writes arrive only with room for two beats
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.num != 2'd0) |-> (r_cnt <= 3'd2))
        else $error("write into full result queue");

    // Pointer distance matches fill level
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) == r_cnt[1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- tb/quoted_string_unescaper_checker.sv -----
// Scoreboard for the quoted string unescaper: predicts decoded beats and checks results.
module quoted_string_unescaper_checker
    import qsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] char_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       last,
    output int         fail_count,
    output int         pending_beats,
    output int         items_seen,
    output int         beats_checked
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BODY,
        ST_ESC,
        ST_HEX,
        ST_OCT
    } t_str_phase;

    // Decoder state mirrored from the input stream
    t_str_phase str_phase;
    logic [7:0] term_char;
    logic [7:0] esc_acc;
    logic [1:0] oct_cnt;

    // Decoded beats still owed by the block, oldest first
    t_beat decoded_q[$];

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end else if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end else if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= "0" && c <= "7");
    endfunction

    task automatic put_beat(input logic [7:0] b, input logic has, input logic fin);
        t_beat bt;
        bt.data_byte = has ? b : 8'h00;
        bt.has_byte  = has;
        bt.last      = fin;
        decoded_q = {decoded_q, bt};
    endtask

    // Handle one byte of the string body: close, start an escape, or pass through
    task automatic take_body(input logic [7:0] c);
        if (c == term_char) begin
            put_beat(8'h00, 1'b0, 1'b1);
            str_phase = ST_IDLE;
        end else if (c == CH_BSLASH) begin
            str_phase = ST_ESC;
        end else begin
            put_beat(c, 1'b1, 1'b0);
            str_phase = ST_BODY;
        end
    endtask

    task automatic predict_item(input logic [1:0] m, input logic [7:0] c);
        int hv;
        hv = 0;
        if (m == MODE_OPEN) begin
            term_char = c;
            esc_acc   = 8'h00;
            oct_cnt   = 2'd0;
            str_phase = ST_BODY;
        end else if (str_phase == ST_IDLE || (m != MODE_CONTENT && m != MODE_END)) begin
            // drop: nothing open, or spare mode
        end else if (m == MODE_END) begin
            // flush a pending numeric escape, then close
            if (str_phase == ST_HEX || str_phase == ST_OCT) begin
                put_beat(esc_acc, 1'b1, 1'b0);
            end
            put_beat(8'h00, 1'b0, 1'b1);
            str_phase = ST_IDLE;
            esc_acc   = 8'h00;
            oct_cnt   = 2'd0;
        end else begin
            case (str_phase)
                ST_BODY: begin
                    take_body(c);
                end
                ST_ESC: begin
                    esc_acc   = 8'h00;
                    oct_cnt   = 2'd0;
                    str_phase = ST_BODY;
                    case (c)
                        CH_LC_B: put_beat(CC_BS, 1'b1, 1'b0);
                        CH_LC_F: put_beat(CC_FF, 1'b1, 1'b0);
                        CH_LC_N: put_beat(CC_LF, 1'b1, 1'b0);
                        CH_LC_R: put_beat(CC_CR, 1'b1, 1'b0);
                        CH_LC_T: put_beat(CC_TAB, 1'b1, 1'b0);
                        CH_LC_X, CH_UC_X: str_phase = ST_HEX;
                        default: begin
                            if (is_octal(c)) begin
                                esc_acc   = {5'd0, c[2:0]};
                                oct_cnt   = 2'd1;
                                str_phase = ST_OCT;
                            end else begin
                                put_beat(c, 1'b1, 1'b0);
                            end
                        end
                    endcase
                end
                ST_HEX: begin
                    hv = hex_value(c);
                    if (hv >= 0) begin
                        esc_acc = {esc_acc[3:0], hv[3:0]};
                    end else begin
                        put_beat(esc_acc, 1'b1, 1'b0);
                        esc_acc = 8'h00;
                        take_body(c);
                    end
                end
                default: begin
                    // octal digits: stop after the third one or at a non-digit
                    if (is_octal(c)) begin
                        esc_acc = {esc_acc[4:0], c[2:0]};
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == OCT_MAX_DIGITS) begin
                            put_beat(esc_acc, 1'b1, 1'b0);
                            esc_acc   = 8'h00;
                            oct_cnt   = 2'd0;
                            str_phase = ST_BODY;
                        end
                    end else begin
                        put_beat(esc_acc, 1'b1, 1'b0);
                        esc_acc = 8'h00;
                        oct_cnt = 2'd0;
                        take_body(c);
                    end
                end
            endcase
        end
    endtask

    // Predict on each input beat, compare each result beat with the oldest prediction
    always @(posedge clk) begin
        if (!rst_n) begin
            str_phase     = ST_IDLE;
            term_char     = 8'h00;
            esc_acc       = 8'h00;
            oct_cnt       = 2'd0;
            decoded_q.delete();
            fail_count    = 0;
            items_seen    = 0;
            beats_checked = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_item(mode, char_in);
                items_seen = items_seen + 1;
            end
            if (out_valid && out_ready) begin
                beats_checked = beats_checked + 1;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected beat: got data %02h has %0b last %0b",
                             $time, data_byte, has_byte, last);
                    fail_count = fail_count + 1;
                end else begin
                    if (data_byte !== decoded_q[0].data_byte) begin
                        $display("%0t: data_byte expected %02h got %02h",
                                 $time, decoded_q[0].data_byte, data_byte);
                        fail_count = fail_count + 1;
                    end
                    if (has_byte !== decoded_q[0].has_byte) begin
                        $display("%0t: has_byte expected %0b got %0b",
                                 $time, decoded_q[0].has_byte, has_byte);
                        fail_count = fail_count + 1;
                    end
                    if (last !== decoded_q[0].last) begin
                        $display("%0t: last expected %0b got %0b",
                                 $time, decoded_q[0].last, last);
                        fail_count = fail_count + 1;
                    end
                    void'(decoded_q.pop_front());
                end
            end
        end
        pending_beats = decoded_q.size();
    end

endmodule

// ----- tb/quoted_string_unescaper_top_tb.sv -----
// Testbench top for the quoted string unescaper: clock, reset, stimulus and verdict.
module quoted_string_unescaper_top_tb;
    import qsu_pkg::*;

    // Spare mode code, ignored by the block
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_ITEMS = 85;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_mode      = MODE_OPEN;
    logic [7:0] i_char_in   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic       o_has_byte;
    logic       o_last;

    int fail_count;
    int pending_beats;
    int items_seen;
    int beats_checked;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int sent_items = 0;
    int cycle_count = 0;

    quoted_string_unescaper_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_in   (i_char_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_byte (o_data_byte),
        .o_has_byte  (o_has_byte),
        .o_last      (o_last)
    );

    quoted_string_unescaper_checker checker_i (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .in_valid      (i_valid),
        .in_ready      (o_in_ready),
        .mode          (i_mode),
        .char_in       (i_char_in),
        .out_valid     (o_out_valid),
        .out_ready     (i_out_ready),
        .data_byte     (o_data_byte),
        .has_byte      (o_has_byte),
        .last          (o_last),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .items_seen    (items_seen),
        .beats_checked (beats_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL quoted_string_unescaper_top");
            $finish;
        end
    end

    // Present one beat after a random gap and hold it until accepted
    task automatic send(input logic [1:0] m, input logic [7:0] c);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_valid   <= 1'b1;
        i_mode    <= m;
        i_char_in <= c;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items = sent_items + 1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send(MODE_CONTENT, s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return 8'("0" + r);
        end else if (r < 16) begin
            return 8'("a" + r - 10);
        end
        return 8'("A" + r - 16);
    endfunction

    // One string: opening quote, a mix of plain bytes and escapes, then a close
    task automatic send_random_string();
        logic [7:0] q;
        int         n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: q = "\"";
            5, 6, 7:       q = "'";
            8:             q = CH_BSLASH;
            default:       q = 8'($urandom_range(0, 255));
        endcase
        send(MODE_OPEN, q);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
                0, 1: send(MODE_CONTENT, 8'($urandom_range(0, 255)));
                2: begin
                    send(MODE_CONTENT, CH_BSLASH);
                    case ($urandom_range(0, 5))
                        0:       send(MODE_CONTENT, CH_LC_B);
                        1:       send(MODE_CONTENT, CH_LC_F);
                        2:       send(MODE_CONTENT, CH_LC_N);
                        3:       send(MODE_CONTENT, CH_LC_R);
                        4:       send(MODE_CONTENT, CH_LC_T);
                        default: send(MODE_CONTENT, 8'($urandom_range(0, 255)));
                    endcase
                end
                3: begin
                    send(MODE_CONTENT, CH_BSLASH);
                    send(MODE_CONTENT, $urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                    n = $urandom_range(0, 4);
                    repeat (n) send(MODE_CONTENT, hex_char());
                end
                4: begin
                    send(MODE_CONTENT, CH_BSLASH);
                    n = $urandom_range(1, 4);
                    repeat (n) send(MODE_CONTENT, 8'("0" + $urandom_range(0, 7)));
                end
                default: begin
                    send(MODE_CONTENT, CH_BSLASH);
                    send(MODE_CONTENT, q);
                end
            endcase
        end
        // Close by terminator mostly, else by end of input, sometimes after a lone backslash
        case ($urandom_range(0, 9))
            0, 1: send(MODE_END, 8'($urandom_range(0, 255)));
            2: begin
                send(MODE_CONTENT, CH_BSLASH);
                send(MODE_END, 8'($urandom_range(0, 255)));
            end
            default: send(MODE_CONTENT, q);
        endcase
    endtask

    initial begin
        int start_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle drops, backslash terminator, all control escapes,
        // full octal, long hex, an abandoned string, empty hex at end, spare mode
        send(MODE_CONTENT, "a");
        send(MODE_END, 8'h00);
        send(MODE_OPEN, CH_BSLASH);
        send(MODE_CONTENT, 8'hFF);
        send(MODE_CONTENT, CH_BSLASH);
        send(MODE_OPEN, "\"");
        send(MODE_CONTENT, 8'h00);
        send_text("\\b\\f\\n\\r\\t\\377\\XfF1\"");
        send(MODE_OPEN, "'");
        send_text("\\7");
        send(MODE_OPEN, "\"");
        send_text("\\x");
        send(MODE_END, 8'hA5);
        send(MODE_SPARE, 8'h5A);

        // Random strings and noise under four idle and stall mixes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            start_items = sent_items;
            while (sent_items - start_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_random_string();
                end else begin
                    send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
        i_valid <= 1'b0;

        // Drain the result side, then let it settle
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d input beats (directed, then four idle/stall mixes).", items_seen);
        $display("Checked %0d result beats against the prediction.", beats_checked);
        if (fail_count == 0) begin
            $display("PASS quoted_string_unescaper_top");
        end else begin
            $display("FAIL quoted_string_unescaper_top");
        end
        $finish;
    end

endmodule

// ----- quoted_string_unescaper_top.f -----
rtl/qsu_pkg.sv
rtl/qsu_decode.sv
rtl/qsu_outq.sv
rtl/quoted_string_unescaper_top.sv
tb/quoted_string_unescaper_checker.sv
tb/quoted_string_unescaper_top_tb.sv
